/* design/oviewt_pkg.sv */
package oviewt_pkg;

    localparam int LAT_WIDTH      = 31;
    localparam int LON_WIDTH      = 32;
    localparam int CLAT2_WIDTH    = LAT_WIDTH + 1;
    localparam int CLON2_WIDTH    = LON_WIDTH + 1;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] RING_MIN_POINTS = 2'd3;
    localparam logic [1:0] LINE_MIN_POINTS = 2'd2;
    localparam logic [1:0] POINTS_SAT      = 2'd3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_LAT_MIN = 2'd0,
        CFG_LAT_MAX = 2'd1,
        CFG_LON_MIN = 2'd2,
        CFG_LON_MAX = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [LAT_WIDTH-1:0] lat_min;
        logic signed [LAT_WIDTH-1:0] lat_max;
        logic signed [LON_WIDTH-1:0] lon_min;
        logic signed [LON_WIDTH-1:0] lon_max;
    } t_view;

    localparam t_view VIEW_RESET = '{
        lat_min: -31'sd900000000,
        lat_max:  31'sd900000000,
        lon_min: -32'sd1800000000,
        lon_max:  32'sd1800000000
    };

    // Per-vertex summary handed from the front end to the crossing pipeline.
    typedef struct packed {
        logic start;
        logic last;
        logic ring;
        logic hit;
        logic overlap;
        logic too_few;
    } t_flags;

endpackage

/* design/oviewt_fifo.sv */
module oviewt_fifo #(
    parameter int DATA_WIDTH = 200
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);
    import oviewt_pkg::*;

    localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  r_wr_ptr;
    logic [PTR_WIDTH-1:0]  r_rd_ptr;
    logic [CNT_WIDTH-1:0]  r_count;

    assign o_full    = (r_count == CNT_WIDTH'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* design/oviewt_front.sv */
module oviewt_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  oviewt_pkg::t_view                     i_view,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [oviewt_pkg::LAT_WIDTH-1:0] i_point_lat,
    input  logic signed [oviewt_pkg::LON_WIDTH-1:0] i_point_lon,
    input  logic                                  i_is_ring,
    input  logic                                  i_last_point,
    input  logic                                  i_queue_full,
    output logic                                  o_push,
    output oviewt_pkg::t_flags                    o_flags,
    output logic signed [COORD_WIDTH-1:0]         o_cur_lat,
    output logic signed [COORD_WIDTH-1:0]         o_cur_lon,
    output logic signed [COORD_WIDTH-1:0]         o_prev_lat,
    output logic signed [COORD_WIDTH-1:0]         o_prev_lon,
    output logic signed [COORD_WIDTH-1:0]         o_first_lat,
    output logic signed [COORD_WIDTH-1:0]         o_first_lon
);
    import oviewt_pkg::*;

    localparam int LAT_EXT = (COORD_WIDTH > LAT_WIDTH) ? COORD_WIDTH : LAT_WIDTH;
    localparam int LON_EXT = (COORD_WIDTH > LON_WIDTH) ? COORD_WIDTH : LON_WIDTH;

    logic signed [LAT_EXT-1:0]     lat_ext;
    logic signed [LON_EXT-1:0]     lon_ext;
    logic signed [COORD_WIDTH-1:0] cur_lat;
    logic signed [COORD_WIDTH-1:0] cur_lon;
    logic signed [LAT_WIDTH-1:0]   v_lat_min;
    logic signed [LAT_WIDTH-1:0]   v_lat_max;
    logic signed [LON_WIDTH-1:0]   v_lon_min;
    logic signed [LON_WIDTH-1:0]   v_lon_max;

    logic signed [COORD_WIDTH-1:0] r_first_lat;
    logic signed [COORD_WIDTH-1:0] r_first_lon;
    logic signed [COORD_WIDTH-1:0] r_prev_lat;
    logic signed [COORD_WIDTH-1:0] r_prev_lon;
    logic signed [COORD_WIDTH-1:0] r_box_lat_low;
    logic signed [COORD_WIDTH-1:0] r_box_lat_high;
    logic signed [COORD_WIDTH-1:0] r_box_lon_low;
    logic signed [COORD_WIDTH-1:0] r_box_lon_high;
    logic                          r_start;
    logic                          r_hit;
    logic [1:0]                    r_points;

    logic       accept;
    logic       vertex_in;
    logic       n_hit;
    logic [1:0] n_points;
    logic       below;
    logic       above;
    logic       west;
    logic       east;

    assign lat_ext = LAT_EXT'(i_point_lat);
    assign lon_ext = LON_EXT'(i_point_lon);
    assign cur_lat = lat_ext[COORD_WIDTH-1:0];
    assign cur_lon = lon_ext[COORD_WIDTH-1:0];

    assign v_lat_min = i_view.lat_min;
    assign v_lat_max = i_view.lat_max;
    assign v_lon_min = i_view.lon_min;
    assign v_lon_max = i_view.lon_max;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    assign vertex_in = (cur_lat >= v_lat_min) && (cur_lat <= v_lat_max) &&
                       (cur_lon >= v_lon_min) && (cur_lon <= v_lon_max);

    // The box after this vertex misses the view on one side only if both the
    // old box and the new vertex do, so the compares run side by side.
    assign below = (r_start || (r_box_lat_high < v_lat_min)) && (cur_lat < v_lat_min);
    assign above = (r_start || (r_box_lat_low > v_lat_max))  && (cur_lat > v_lat_max);
    assign west  = (r_start || (r_box_lon_high < v_lon_min)) && (cur_lon < v_lon_min);
    assign east  = (r_start || (r_box_lon_low > v_lon_max))  && (cur_lon > v_lon_max);

    always_comb begin
        if (r_start) begin
            n_hit    = vertex_in;
            n_points = 2'd1;
        end else begin
            n_hit    = r_hit || vertex_in;
            n_points = (r_points == POINTS_SAT) ? POINTS_SAT : r_points + 2'd1;
        end
    end

    assign o_flags.start   = r_start;
    assign o_flags.last    = i_last_point;
    assign o_flags.ring    = i_is_ring;
    assign o_flags.hit     = n_hit;
    assign o_flags.overlap = !(below || above || west || east);
    assign o_flags.too_few = i_is_ring ? (n_points < RING_MIN_POINTS)
                                       : (n_points < LINE_MIN_POINTS);

    assign o_cur_lat   = cur_lat;
    assign o_cur_lon   = cur_lon;
    assign o_prev_lat  = r_prev_lat;
    assign o_prev_lon  = r_prev_lon;
    assign o_first_lat = r_start ? cur_lat : r_first_lat;
    assign o_first_lon = r_start ? cur_lon : r_first_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 1'b1;
            r_hit    <= 1'b0;
            r_points <= '0;
        end else if (accept) begin
            r_start  <= i_last_point;
            r_hit    <= n_hit;
            r_points <= n_points;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_lat <= cur_lat;
            r_prev_lon <= cur_lon;
            if (r_start) begin
                r_first_lat    <= cur_lat;
                r_first_lon    <= cur_lon;
                r_box_lat_low  <= cur_lat;
                r_box_lat_high <= cur_lat;
                r_box_lon_low  <= cur_lon;
                r_box_lon_high <= cur_lon;
            end else begin
                if (cur_lat < r_box_lat_low) begin
                    r_box_lat_low <= cur_lat;
                end
                if (cur_lat > r_box_lat_high) begin
                    r_box_lat_high <= cur_lat;
                end
                if (cur_lon < r_box_lon_low) begin
                    r_box_lon_low <= cur_lon;
                end
                if (cur_lon > r_box_lon_high) begin
                    r_box_lon_high <= cur_lon;
                end
            end
        end
    end

endmodule

/* design/oviewt_edge.sv */
module oviewt_edge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic signed [COORD_WIDTH-1:0]             i_a_lat,
    input  logic signed [COORD_WIDTH-1:0]             i_a_lon,
    input  logic signed [COORD_WIDTH-1:0]             i_b_lat,
    input  logic signed [COORD_WIDTH-1:0]             i_b_lon,
    input  logic signed [oviewt_pkg::CLAT2_WIDTH-1:0] i_clat2,
    input  logic signed [oviewt_pkg::CLON2_WIDTH-1:0] i_clon2,
    output logic                                      o_cross
);
    import oviewt_pkg::*;

    // Operands of both cross products fit in EW bits; each product is built
    // from four half-width partial products.
    localparam int EW = ((COORD_WIDTH > LON_WIDTH) ? COORD_WIDTH : LON_WIDTH) + 2;
    localparam int H  = EW / 2;
    localparam int HW = EW - H;
    localparam int PW = 2 * EW;

    logic signed [EW-1:0] a_lat;
    logic signed [EW-1:0] a_lon;
    logic signed [EW-1:0] b_lat;
    logic signed [EW-1:0] b_lon;
    logic signed [EW-1:0] clat2;
    logic signed [EW-1:0] clon2;
    logic signed [EW-1:0] n_d;

    // first stage: operands
    logic                 r_s1_side;
    logic                 r_s1_dpos;
    logic signed [EW-1:0] r_lhs_p;
    logic signed [EW-1:0] r_lhs_q;
    logic signed [EW-1:0] r_rhs_p;
    logic signed [EW-1:0] r_rhs_q;

    // second stage: partial products
    logic                     r_s2_side;
    logic                     r_s2_dpos;
    logic signed [2*HW-1:0]   r_lhs_hh;
    logic signed [HW+H:0]     r_lhs_hl;
    logic signed [HW+H:0]     r_lhs_lh;
    logic [2*H-1:0]           r_lhs_ll;
    logic signed [2*HW-1:0]   r_rhs_hh;
    logic signed [HW+H:0]     r_rhs_hl;
    logic signed [HW+H:0]     r_rhs_lh;
    logic [2*H-1:0]           r_rhs_ll;

    // third stage: full products
    logic                 r_s3_side;
    logic                 r_s3_dpos;
    logic signed [PW-1:0] r_lhs;
    logic signed [PW-1:0] r_rhs;

    logic signed [HW-1:0] lhs_ph;
    logic signed [HW-1:0] lhs_qh;
    logic signed [H:0]    lhs_pl;
    logic signed [H:0]    lhs_ql;
    logic signed [HW-1:0] rhs_ph;
    logic signed [HW-1:0] rhs_qh;
    logic signed [H:0]    rhs_pl;
    logic signed [H:0]    rhs_ql;

    logic signed [PW-1:0] lhs_sum;
    logic signed [PW-1:0] rhs_sum;

    assign a_lat = EW'(i_a_lat);
    assign a_lon = EW'(i_a_lon);
    assign b_lat = EW'(i_b_lat);
    assign b_lon = EW'(i_b_lon);
    assign clat2 = EW'(i_clat2);
    assign clon2 = EW'(i_clon2);
    assign n_d   = b_lat - a_lat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_side <= ((a_lat <<< 1) > clat2) != ((b_lat <<< 1) > clat2);
            r_s1_dpos <= (n_d > 0);
            r_lhs_p   <= clon2 - (a_lon <<< 1);
            r_lhs_q   <= n_d;
            r_rhs_p   <= b_lon - a_lon;
            r_rhs_q   <= clat2 - (a_lat <<< 1);
        end
    end

    assign lhs_ph = r_lhs_p[EW-1:H];
    assign lhs_qh = r_lhs_q[EW-1:H];
    assign lhs_pl = {1'b0, r_lhs_p[H-1:0]};
    assign lhs_ql = {1'b0, r_lhs_q[H-1:0]};
    assign rhs_ph = r_rhs_p[EW-1:H];
    assign rhs_qh = r_rhs_q[EW-1:H];
    assign rhs_pl = {1'b0, r_rhs_p[H-1:0]};
    assign rhs_ql = {1'b0, r_rhs_q[H-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_side <= r_s1_side;
            r_s2_dpos <= r_s1_dpos;
            r_lhs_hh  <= lhs_ph * lhs_qh;
            r_lhs_hl  <= lhs_ph * lhs_ql;
            r_lhs_lh  <= lhs_pl * lhs_qh;
            r_lhs_ll  <= r_lhs_p[H-1:0] * r_lhs_q[H-1:0];
            r_rhs_hh  <= rhs_ph * rhs_qh;
            r_rhs_hl  <= rhs_ph * rhs_ql;
            r_rhs_lh  <= rhs_pl * rhs_qh;
            r_rhs_ll  <= r_rhs_p[H-1:0] * r_rhs_q[H-1:0];
        end
    end

    assign lhs_sum = (PW'(r_lhs_hh) <<< (2 * H)) + (PW'(r_lhs_hl) <<< H) +
                     (PW'(r_lhs_lh) <<< H) + $signed(PW'(r_lhs_ll));
    assign rhs_sum = (PW'(r_rhs_hh) <<< (2 * H)) + (PW'(r_rhs_hl) <<< H) +
                     (PW'(r_rhs_lh) <<< H) + $signed(PW'(r_rhs_ll));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_side <= r_s2_side;
            r_s3_dpos <= r_s2_dpos;
            r_lhs     <= lhs_sum;
            r_rhs     <= rhs_sum;
        end
    end

    // The edge straddles the centre latitude and meets the ray east of the centre.
    assign o_cross = r_s3_side && (r_s3_dpos ? (r_lhs < r_rhs) : (r_rhs < r_lhs));

endmodule

/* design/oviewt_back.sv */
module oviewt_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oviewt_pkg::t_view             i_view,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  oviewt_pkg::t_flags            i_flags,
    input  logic signed [COORD_WIDTH-1:0] i_cur_lat,
    input  logic signed [COORD_WIDTH-1:0] i_cur_lon,
    input  logic signed [COORD_WIDTH-1:0] i_prev_lat,
    input  logic signed [COORD_WIDTH-1:0] i_prev_lon,
    input  logic signed [COORD_WIDTH-1:0] i_first_lat,
    input  logic signed [COORD_WIDTH-1:0] i_first_lon,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_touches_view,
    output logic                          o_vertex_in_view,
    output logic                          o_encloses_center,
    output logic                          o_too_few_points
);
    import oviewt_pkg::*;

    logic signed [LAT_WIDTH-1:0]   v_lat_min;
    logic signed [LAT_WIDTH-1:0]   v_lat_max;
    logic signed [LON_WIDTH-1:0]   v_lon_min;
    logic signed [LON_WIDTH-1:0]   v_lon_max;
    logic signed [CLAT2_WIDTH-1:0] r_clat2;
    logic signed [CLON2_WIDTH-1:0] r_clon2;

    logic [2:0] r_valid;
    t_flags     r_s1_flags;
    t_flags     r_s2_flags;
    t_flags     r_s3_flags;
    logic       r_parity;
    logic       r_out_valid;
    logic       r_touches;
    logic       r_vertex_in;
    logic       r_encloses;
    logic       r_too_few;

    logic en;
    logic cross_step;
    logic cross_close;
    logic n_parity;
    logic encloses;

    assign v_lat_min = i_view.lat_min;
    assign v_lat_max = i_view.lat_max;
    assign v_lon_min = i_view.lon_min;
    assign v_lon_max = i_view.lon_max;

    // Doubled view centre, so that it stays an integer.
    always_ff @(posedge i_clk) begin
        r_clat2 <= CLAT2_WIDTH'(v_lat_min) + CLAT2_WIDTH'(v_lat_max);
        r_clon2 <= CLON2_WIDTH'(v_lon_min) + CLON2_WIDTH'(v_lon_max);
    end

    // The pipeline only halts while a result sits untaken in the output register.
    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    oviewt_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_step (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a_lat(i_cur_lat),
        .i_a_lon(i_cur_lon),
        .i_b_lat(i_prev_lat),
        .i_b_lon(i_prev_lon),
        .i_clat2(r_clat2),
        .i_clon2(r_clon2),
        .o_cross(cross_step)
    );

    oviewt_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_close (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a_lat(i_first_lat),
        .i_a_lon(i_first_lon),
        .i_b_lat(i_cur_lat),
        .i_b_lon(i_cur_lon),
        .i_clat2(r_clat2),
        .i_clon2(r_clon2),
        .o_cross(cross_close)
    );

    assign n_parity = (r_s3_flags.start ? 1'b0 : (r_parity ^ cross_step)) ^
                      (r_s3_flags.last & cross_close);
    assign encloses = r_s3_flags.ring && r_s3_flags.overlap && n_parity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid     <= {r_valid[1:0], o_pop};
            r_out_valid <= r_valid[2] && r_s3_flags.last;
            if (r_valid[2]) begin
                r_parity <= n_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_flags <= i_flags;
            r_s2_flags <= r_s1_flags;
            r_s3_flags <= r_s2_flags;
            if (r_valid[2] && r_s3_flags.last) begin
                r_touches   <= !r_s3_flags.too_few && (r_s3_flags.hit || encloses);
                r_vertex_in <= r_s3_flags.hit;
                r_encloses  <= encloses;
                r_too_few   <= r_s3_flags.too_few;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_touches_view    = r_touches;
    assign o_vertex_in_view  = r_vertex_in;
    assign o_encloses_center = r_encloses;
    assign o_too_few_points  = r_too_few;

endmodule

/* design/outline_view_overlap_test.sv */
// A result is registered at the output once the transaction that carries the last
// vertex of an outline has passed the queue and the three crossing stages.
// Throughput: one vertex per cycle while no result waits untaken at the output, set
// by the three-stage crossing pipeline and its split cross-product multipliers; a
// four-entry queue sits before it. Reset (synchronous, active low) starts a new
// outline and sets the view to the whole globe.
module outline_view_overlap_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [oviewt_pkg::CFG_IDX_WIDTH-1:0]        i_cfg_index,
    input  logic [oviewt_pkg::CFG_DATA_WIDTH-1:0]       i_cfg_data,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic signed [oviewt_pkg::LAT_WIDTH-1:0]     i_point_lat,
    input  logic signed [oviewt_pkg::LON_WIDTH-1:0]     i_point_lon,
    input  logic                                        i_is_ring,
    input  logic                                        i_last_point,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic                                        o_touches_view,
    output logic                                        o_vertex_in_view,
    output logic                                        o_encloses_center,
    output logic                                        o_too_few_points
);
    import oviewt_pkg::*;

    localparam int JOB_WIDTH = $bits(t_flags) + 6 * COORD_WIDTH;

    t_view r_view;

    logic                          queue_full;
    logic                          queue_empty;
    logic                          push;
    logic                          pop;
    logic [JOB_WIDTH-1:0]          wr_job;
    logic [JOB_WIDTH-1:0]          rd_job;
    t_flags                        fr_flags;
    logic signed [COORD_WIDTH-1:0] fr_cur_lat;
    logic signed [COORD_WIDTH-1:0] fr_cur_lon;
    logic signed [COORD_WIDTH-1:0] fr_prev_lat;
    logic signed [COORD_WIDTH-1:0] fr_prev_lon;
    logic signed [COORD_WIDTH-1:0] fr_first_lat;
    logic signed [COORD_WIDTH-1:0] fr_first_lon;
    t_flags                        bk_flags;
    logic signed [COORD_WIDTH-1:0] bk_cur_lat;
    logic signed [COORD_WIDTH-1:0] bk_cur_lon;
    logic signed [COORD_WIDTH-1:0] bk_prev_lat;
    logic signed [COORD_WIDTH-1:0] bk_prev_lon;
    logic signed [COORD_WIDTH-1:0] bk_first_lat;
    logic signed [COORD_WIDTH-1:0] bk_first_lon;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view <= VIEW_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LAT_MIN: r_view.lat_min <= i_cfg_data[LAT_WIDTH-1:0];
                CFG_LAT_MAX: r_view.lat_max <= i_cfg_data[LAT_WIDTH-1:0];
                CFG_LON_MIN: r_view.lon_min <= i_cfg_data[LON_WIDTH-1:0];
                CFG_LON_MAX: r_view.lon_max <= i_cfg_data[LON_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    oviewt_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_view      (r_view),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_point_lat (i_point_lat),
        .i_point_lon (i_point_lon),
        .i_is_ring   (i_is_ring),
        .i_last_point(i_last_point),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_flags     (fr_flags),
        .o_cur_lat   (fr_cur_lat),
        .o_cur_lon   (fr_cur_lon),
        .o_prev_lat  (fr_prev_lat),
        .o_prev_lon  (fr_prev_lon),
        .o_first_lat (fr_first_lat),
        .o_first_lon (fr_first_lon)
    );

    assign wr_job = {fr_flags, fr_cur_lat, fr_cur_lon, fr_prev_lat, fr_prev_lon,
                     fr_first_lat, fr_first_lon};

    oviewt_fifo #(
        .DATA_WIDTH(JOB_WIDTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_data(wr_job),
        .i_pop    (pop),
        .o_rd_data(rd_job),
        .o_full   (queue_full),
        .o_empty  (queue_empty)
    );

    assign {bk_flags, bk_cur_lat, bk_cur_lon, bk_prev_lat, bk_prev_lon,
            bk_first_lat, bk_first_lon} = rd_job;

    oviewt_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_view           (r_view),
        .i_empty          (queue_empty),
        .o_pop            (pop),
        .i_flags          (bk_flags),
        .i_cur_lat        (bk_cur_lat),
        .i_cur_lon        (bk_cur_lon),
        .i_prev_lat       (bk_prev_lat),
        .i_prev_lon       (bk_prev_lon),
        .i_first_lat      (bk_first_lat),
        .i_first_lon      (bk_first_lon),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_touches_view   (o_touches_view),
        .o_vertex_in_view (o_vertex_in_view),
        .o_encloses_center(o_encloses_center),
        .o_too_few_points (o_too_few_points)
    );

endmodule

/* sim/outline_view_overlap_test_chk.sv */
`timescale 1ns / 100ps

module outline_view_overlap_test_chk (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_valid,
    input  logic                                      i_cfg_ready,
    input  logic [oviewt_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  logic [oviewt_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_ready,
    input  logic signed [oviewt_pkg::LAT_WIDTH-1:0]   i_point_lat,
    input  logic signed [oviewt_pkg::LON_WIDTH-1:0]   i_point_lon,
    input  logic                                      i_is_ring,
    input  logic                                      i_last_point,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_ready,
    input  logic                                      i_touches_view,
    input  logic                                      i_vertex_in_view,
    input  logic                                      i_encloses_center,
    input  logic                                      i_too_few_points,
    output int                                        o_fail_count,
    output int                                        o_pending
);
    import oviewt_pkg::*;

    typedef struct packed {
        logic touches;
        logic vertex_in;
        logic encloses;
        logic too_few;
    } t_verdict;

    t_verdict verdict_q[$];
    t_verdict want;

    // View as currently programmed, widened for exact arithmetic.
    longint vw_lat_min, vw_lat_max, vw_lon_min, vw_lon_max;

    // Running state of the outline being received.
    longint first_lat, first_lon, prev_lat, prev_lon;
    longint box_lat_low, box_lat_high, box_lon_low, box_lon_high;
    bit     hit_seen;
    bit     parity;
    bit     new_outline;
    int     points;
    int     fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = verdict_q.size();

    function automatic bit vertex_inside(longint lat, longint lon);
        return lat >= vw_lat_min && lat <= vw_lat_max &&
               lon >= vw_lon_min && lon <= vw_lon_max;
    endfunction

    // An eastward ray from the view centre is crossed by edge a-b. The centre is kept
    // doubled, so the crossing test is a comparison of two exact cross products.
    function automatic bit ray_crosses(longint alat, longint alon, longint blat,
                                       longint blon);
        longint               clat2;
        longint               clon2;
        longint               d;
        logic signed [127:0]  w1;
        logic signed [127:0]  w2;
        logic signed [127:0]  lhs;
        logic signed [127:0]  rhs;
        clat2 = vw_lat_min + vw_lat_max;
        clon2 = vw_lon_min + vw_lon_max;
        if ((2 * alat > clat2) == (2 * blat > clat2))
            return 1'b0;
        d   = blat - alat;
        w1  = clon2 - 2 * alon;
        w2  = d;
        lhs = w1 * w2;
        w1  = blon - alon;
        w2  = clat2 - 2 * alat;
        rhs = w1 * w2;
        return (d > 0) ? (lhs < rhs) : (rhs < lhs);
    endfunction

    function automatic void take_vertex(longint lat, longint lon, bit ring, bit last);
        t_verdict v;
        bit       overlap;
        bit       few;
        if (new_outline) begin
            first_lat    = lat;
            prev_lat     = lat;
            box_lat_low  = lat;
            box_lat_high = lat;
            first_lon    = lon;
            prev_lon     = lon;
            box_lon_low  = lon;
            box_lon_high = lon;
            hit_seen     = vertex_inside(lat, lon);
            parity       = 1'b0;
            points       = 1;
        end else begin
            if (ray_crosses(lat, lon, prev_lat, prev_lon))
                parity = !parity;
            if (lat < box_lat_low)  box_lat_low  = lat;
            if (lat > box_lat_high) box_lat_high = lat;
            if (lon < box_lon_low)  box_lon_low  = lon;
            if (lon > box_lon_high) box_lon_high = lon;
            if (vertex_inside(lat, lon))
                hit_seen = 1'b1;
            if (points < POINTS_SAT)
                points++;
            prev_lat = lat;
            prev_lon = lon;
        end
        new_outline = last;
        if (last) begin
            // The closing edge back to the first vertex; degenerate for a single point.
            if (ray_crosses(first_lat, first_lon, lat, lon))
                parity = !parity;
            overlap = !(box_lat_high < vw_lat_min || box_lat_low > vw_lat_max ||
                        box_lon_high < vw_lon_min || box_lon_low > vw_lon_max);
            few         = points < (ring ? RING_MIN_POINTS : LINE_MIN_POINTS);
            v.encloses  = ring && overlap && parity;
            v.vertex_in = hit_seen;
            v.too_few   = few;
            v.touches   = !few && (hit_seen || v.encloses);
            verdict_q.insert(verdict_q.size(), v);
        end
    endfunction

    function automatic void check_field(string name, logic exp_val, logic got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vw_lat_min   = longint'(VIEW_RESET.lat_min);
            vw_lat_max   = longint'(VIEW_RESET.lat_max);
            vw_lon_min   = longint'(VIEW_RESET.lon_min);
            vw_lon_max   = longint'(VIEW_RESET.lon_max);
            first_lat    = 0;
            first_lon    = 0;
            prev_lat     = 0;
            prev_lon     = 0;
            box_lat_low  = 0;
            box_lat_high = 0;
            box_lon_low  = 0;
            box_lon_high = 0;
            hit_seen     = 1'b0;
            parity       = 1'b0;
            points       = 0;
            new_outline  = 1'b1;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LAT_MIN: vw_lat_min = longint'($signed(i_cfg_data[LAT_WIDTH-1:0]));
                    CFG_LAT_MAX: vw_lat_max = longint'($signed(i_cfg_data[LAT_WIDTH-1:0]));
                    CFG_LON_MIN: vw_lon_min = longint'($signed(i_cfg_data[LON_WIDTH-1:0]));
                    CFG_LON_MAX: vw_lon_max = longint'($signed(i_cfg_data[LON_WIDTH-1:0]));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_vertex(longint'(i_point_lat), longint'(i_point_lon), i_is_ring,
                            i_last_point);
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result transaction arrived with no outline outstanding");
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("touches_view", want.touches, i_touches_view);
                    check_field("vertex_in_view", want.vertex_in, i_vertex_in_view);
                    check_field("encloses_center", want.encloses, i_encloses_center);
                    check_field("too_few_points", want.too_few, i_too_few_points);
                end
            end
        end
    end

endmodule

/* sim/tb_outline_view_overlap_test.sv */
`timescale 1ns / 100ps

module tb_outline_view_overlap_test;
    import oviewt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int SETTLE       = 16;
    localparam longint SPAN_CAP = 64'd4000000000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;
    typedef enum int {VIEW_GLOBE, VIEW_BOX, VIEW_TIGHT, VIEW_INVERTED, VIEW_RAW} t_view_kind;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]    i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic signed [LAT_WIDTH-1:0]  i_point_lat = '0;
    logic signed [LON_WIDTH-1:0]  i_point_lon = '0;
    logic                         i_is_ring = 1'b0;
    logic                         i_last_point = 1'b0;
    logic                         i_out_ready = 1'b0;
    logic                         o_cfg_ready;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic                         o_touches_view;
    logic                         o_vertex_in_view;
    logic                         o_encloses_center;
    logic                         o_too_few_points;

    int       fail_count;
    int       pending;
    int       items_sent = 0;
    int       burst_left = 0;
    int       cycles = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_phase = 0;

    // Stimulus-side copy of the view, used only to aim outlines at its centre.
    longint v_lat_min = longint'(VIEW_RESET.lat_min);
    longint v_lat_max = longint'(VIEW_RESET.lat_max);
    longint v_lon_min = longint'(VIEW_RESET.lon_min);
    longint v_lon_max = longint'(VIEW_RESET.lon_max);

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    outline_view_overlap_test u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_point_lat       (i_point_lat),
        .i_point_lon       (i_point_lon),
        .i_is_ring         (i_is_ring),
        .i_last_point      (i_last_point),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_touches_view    (o_touches_view),
        .o_vertex_in_view  (o_vertex_in_view),
        .o_encloses_center (o_encloses_center),
        .o_too_few_points  (o_too_few_points)
    );

    outline_view_overlap_test_chk u_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_point_lat       (i_point_lat),
        .i_point_lon       (i_point_lon),
        .i_is_ring         (i_is_ring),
        .i_last_point      (i_last_point),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_touches_view    (o_touches_view),
        .i_vertex_in_view  (o_vertex_in_view),
        .i_encloses_center (o_encloses_center),
        .i_too_few_points  (o_too_few_points),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // The result side switches at random between four stall patterns.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     i_out_ready = 1'b1;
            RX_COIN:     i_out_ready = 1'($urandom_range(0, 1));
            RX_SPARSE:   i_out_ready = ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_out_ready = ((rx_phase % 7) < 4);
            default:     i_out_ready = 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        case (idx)
            CFG_LAT_MIN: v_lat_min = longint'($signed(data[LAT_WIDTH-1:0]));
            CFG_LAT_MAX: v_lat_max = longint'($signed(data[LAT_WIDTH-1:0]));
            CFG_LON_MIN: v_lon_min = longint'($signed(data[LON_WIDTH-1:0]));
            CFG_LON_MAX: v_lon_max = longint'($signed(data[LON_WIDTH-1:0]));
            default: ;
        endcase
    endtask

    // Vertices go out in bursts; valid drops in a gap before each burst.
    task automatic send_vertex(input longint lat, input longint lon, input bit ring,
                               input bit last);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid   = 1'b1;
        i_point_lat  = lat[LAT_WIDTH-1:0];
        i_point_lon  = lon[LON_WIDTH-1:0];
        i_is_ring    = ring;
        i_last_point = last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Waits until every result is in and the pipeline has emptied of vertices
    // that produce no result, so that the view may be rewritten safely.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // An outline scattered about the view centre. When it goes around, the vertices
    // visit the quadrants in turn, so rings usually enclose the centre.
    task automatic send_outline(input int n, input bit ring, input bit around,
                                input bit flip_flag);
        longint clat;
        longint clon;
        longint slat;
        longint slon;
        longint dlat;
        longint dlon;
        int     q;
        int     reach;
        bit     ring_now;
        clat  = (v_lat_min + v_lat_max) / 2;
        clon  = (v_lon_min + v_lon_max) / 2;
        slat  = ((v_lat_max > v_lat_min) ? v_lat_max - v_lat_min : v_lat_min - v_lat_max) / 2;
        slon  = ((v_lon_max > v_lon_min) ? v_lon_max - v_lon_min : v_lon_min - v_lon_max) / 2;
        reach = $urandom_range(0, 3);
        case (reach)
            0: begin slat = 1000; slon = 1000; end
            1: begin slat = slat / 4; slon = slon / 4; end
            3: begin slat = slat * 2; slon = slon * 2; end
            default: ;
        endcase
        slat = (slat > SPAN_CAP) ? SPAN_CAP : slat + 1;
        slon = (slon > SPAN_CAP) ? SPAN_CAP : slon + 1;
        for (int k = 0; k < n; k++) begin
            dlat = longint'($urandom_range(1, int'(slat)));
            dlon = longint'($urandom_range(1, int'(slon)));
            if (around) begin
                q = (k * 4) / n;
                if (q == 2 || q == 3) dlat = -dlat;
                if (q == 1 || q == 2) dlon = -dlon;
            end else begin
                if ($urandom_range(0, 1)) dlat = -dlat;
                if ($urandom_range(0, 1)) dlon = -dlon;
            end
            ring_now = (flip_flag && k != n - 1) ? 1'($urandom_range(0, 1)) : ring;
            send_vertex(clat + dlat, clon + dlon, ring_now, k == n - 1);
        end
    endtask

    task automatic pick_view(input t_view_kind kind);
        longint                   lim[4];
        longint                   c;
        longint                   h;
        longint                   tmp;
        logic [CFG_DATA_WIDTH-1:0] r;
        int                       rot;
        t_cfg_idx                 idx;
        logic [CFG_DATA_WIDTH-1:0] data;
        lim[CFG_LAT_MIN] = longint'(VIEW_RESET.lat_min);
        lim[CFG_LAT_MAX] = longint'(VIEW_RESET.lat_max);
        lim[CFG_LON_MIN] = longint'(VIEW_RESET.lon_min);
        lim[CFG_LON_MAX] = longint'(VIEW_RESET.lon_max);
        if (kind == VIEW_BOX || kind == VIEW_TIGHT || kind == VIEW_INVERTED) begin
            c = longint'($urandom_range(0, 1800000000)) - 900000000;
            h = (kind == VIEW_TIGHT) ? longint'($urandom_range(0, 5000))
                                     : longint'($urandom_range(1, 400000000));
            lim[CFG_LAT_MIN] = c - h;
            lim[CFG_LAT_MAX] = c + h;
            c = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
            h = (kind == VIEW_TIGHT) ? longint'($urandom_range(0, 5000))
                                     : longint'($urandom_range(1, 800000000));
            lim[CFG_LON_MIN] = c - h;
            lim[CFG_LON_MAX] = c + h;
        end
        if (kind == VIEW_INVERTED) begin
            if ($urandom_range(0, 1)) begin
                tmp = lim[CFG_LAT_MIN];
                lim[CFG_LAT_MIN] = lim[CFG_LAT_MAX];
                lim[CFG_LAT_MAX] = tmp;
            end else begin
                tmp = lim[CFG_LON_MIN];
                lim[CFG_LON_MIN] = lim[CFG_LON_MAX];
                lim[CFG_LON_MAX] = tmp;
            end
        end
        if (kind == VIEW_RAW) begin
            // Any bit pattern, with the largest and smallest encodings favoured.
            for (int i = 0; i < 4; i++) begin
                r = $urandom;
                case ($urandom_range(0, 2))
                    0: r = (i < 2) ? 32'h3FFF_FFFF : 32'h7FFF_FFFF;
                    1: r = (i < 2) ? 32'h4000_0000 : 32'h8000_0000;
                    default: ;
                endcase
                lim[i] = (i < 2) ? longint'($signed(r[LAT_WIDTH-1:0]))
                                 : longint'($signed(r));
            end
        end
        rot = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
            idx  = t_cfg_idx'((i + rot) % 4);
            data = lim[idx][CFG_DATA_WIDTH-1:0];
            // The top bit of a latitude write is unused; set it at random anyway.
            if (idx == CFG_LAT_MIN || idx == CFG_LAT_MAX)
                data[CFG_DATA_WIDTH-1] = 1'($urandom_range(0, 1));
            write_reg(idx, data);
        end
    endtask

    initial begin
        int         random_start;
        int         phase;
        int         phase_end;
        int         roll;
        t_view_kind kind;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Lone point on a line, then a two-point line and a two-point ring.
        send_vertex(0, 0, 1'b0, 1'b1);
        send_vertex(100, 200, 1'b0, 1'b0);
        send_vertex(300, -400, 1'b0, 1'b1);
        send_vertex(100, 200, 1'b1, 1'b0);
        send_vertex(300, -400, 1'b1, 1'b1);
        // The ring flag on the closing vertex decides.
        send_vertex(10, 10, 1'b0, 1'b0);
        send_vertex(-10, 20, 1'b0, 1'b0);
        send_vertex(0, -30, 1'b1, 1'b1);
        // Extreme encodings and the edges of the legal range.
        send_vertex(64'sh3FFF_FFFF, 64'sh7FFF_FFFF, 1'b1, 1'b0);
        send_vertex(-64'sh4000_0000, -64'sh8000_0000, 1'b1, 1'b0);
        send_vertex(900000000, -1800000000, 1'b1, 1'b0);
        send_vertex(-900000000, 1800000000, 1'b1, 1'b1);
        settle();

        // A tiny view inside a large square: enclosed with no vertex in view.
        write_reg(CFG_LAT_MIN, -32'sd1000);
        write_reg(CFG_LAT_MAX, 32'sd1000);
        write_reg(CFG_LON_MIN, -32'sd2000);
        write_reg(CFG_LON_MAX, 32'sd2000);
        send_vertex(1000000, 1000000, 1'b1, 1'b0);
        send_vertex(1000000, -1000000, 1'b1, 1'b0);
        settle();
        // The view moves while the ring is still open.
        write_reg(CFG_LON_MAX, 32'sd3000);
        send_vertex(-1000000, -1000000, 1'b1, 1'b0);
        send_vertex(-1000000, 1000000, 1'b1, 1'b1);
        send_vertex(1000000, 1000000, 1'b0, 1'b0);
        send_vertex(1000000, -1000000, 1'b0, 1'b0);
        send_vertex(-1000000, -1000000, 1'b0, 1'b0);
        send_vertex(-1000000, 1000000, 1'b0, 1'b1);
        settle();

        // Inverted latitude bounds around a ring that encloses the centre.
        write_reg(CFG_LAT_MIN, 32'sd1000);
        write_reg(CFG_LAT_MAX, -32'sd1000);
        send_vertex(500000, 0, 1'b1, 1'b0);
        send_vertex(-500000, 500000, 1'b1, 1'b0);
        send_vertex(-500000, -500000, 1'b1, 1'b1);

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            settle();
            kind = (phase <= VIEW_RAW) ? t_view_kind'(phase) : t_view_kind'($urandom_range(0, 4));
            pick_view(kind);
            phase++;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    repeat ($urandom_range(1, 4))
                        send_vertex(longint'($urandom), longint'($urandom),
                                    1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
                end else if (roll < 18) begin
                    send_outline(int'($urandom_range(1, 2)), 1'($urandom_range(0, 1)),
                                 1'b0, 1'b0);
                end else begin
                    send_outline(int'($urandom_range(3, 10)), $urandom_range(0, 3) != 0,
                                 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
                end
            end
        end
        settle();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
